@@ hdl/sme_pkg.sv @@
// Package with shared types and constants for the stable matching engine.
package sme_pkg;
   localparam int DEFAULT_MAX_PAIRS = 16;
   localparam int RANK_W = 5;
   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] CNT_SAT = 5'd31;

   typedef enum logic [1:0] {
      CMD_LOAD_PROP = 2'd0,
      CMD_LOAD_ACC  = 2'd1,
      CMD_RUN       = 2'd2,
      CMD_QUERY     = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_FIND,
      ST_SCAN_ADDR,
      ST_SCAN,
      ST_ACC_ADDR,
      ST_ACC_PREV,
      ST_ACC_NEW,
      ST_DECIDE,
      ST_QUERY,
      ST_REPLY
   } state_type;
endpackage

@@ hdl/stable_matching_engine_core.sv @@
// Top level of the stable matching engine: control sequencer and state memories.
//
//  channel   direction  tdata fields (low bit up)                 tuser
//  req       in         proposer, acceptor, rank_value            cmd
//  rsp       out        proposals, partner, partner_valid         reply_kind
//  csr       in         pairs_in_use (write only)                 -
//
// A run first clears the strike marks one entry per cycle over every proposer and
// acceptor slot, clearing the acceptor and proposer tables along the way. Each
// proposal then scans the proposer's rank row, reads the chosen acceptor and, when
// the acceptor is already engaged, compares the two acceptor ranks; busy proposers
// are skipped. The serial scan of one proposer's rank row through the single read
// port of the proposer rank memory dominates.
// Reset is synchronous and starts the same clearing pass; the rank memories are
// undefined until loaded. While a result waits on rsp, req is not accepted.
module stable_matching_engine_core #(
   parameter int MAX_PAIRS = sme_pkg::DEFAULT_MAX_PAIRS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // proposer[3:0], acceptor[7:4], rank_value[12:8]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // proposals[4:0], partner[8:5], partner_valid[9]
   output logic        rsp_tuser,   // reply_kind
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data  // pairs_in_use
);
   import sme_pkg::*;
   localparam int IW = $clog2(MAX_PAIRS);
   localparam int AW = 2 * IW;
   localparam int DEPTH = 1 << AW;
   localparam int PW = $clog2(MAX_PAIRS + 1);
   localparam int GW = $clog2(MAX_PAIRS * MAX_PAIRS + MAX_PAIRS + 1);
   localparam logic [GW-1:0] GUARD_INIT = GW'(MAX_PAIRS * MAX_PAIRS + MAX_PAIRS);

   // Request fields; indices of MAX_PAIRS and above are detected on the 4-bit field.
   logic [3:0] f_prop, f_acc;
   logic [4:0] f_rank;
   cmd_type    f_cmd;
   assign f_prop = req_tdata[3:0];
   assign f_acc  = req_tdata[7:4];
   assign f_rank = req_tdata[12:8];
   assign f_cmd  = cmd_type'(req_tuser);
   logic p_ok, a_ok;
   assign p_ok = 32'(f_prop) < MAX_PAIRS;
   assign a_ok = 32'(f_acc) < MAX_PAIRS;

   logic [4:0] pairs_ff;
   always_ff @(posedge clock) begin
      if (reset) pairs_ff <= 5'd16;
      else if (csr_wr_en) pairs_ff <= csr_wr_data;
   end
   logic [PW-1:0] n_act;
   always_comb begin
      if (pairs_ff == 5'd0) n_act = PW'(1);
      else if (32'(pairs_ff) > MAX_PAIRS) n_act = PW'(MAX_PAIRS);
      else n_act = PW'(pairs_ff);
   end

   // Per-entry state memories (acceptor table, proposer busy, strike marks).
   logic [IW-1:0]   eng_mem [MAX_PAIRS];
   logic            engv_mem [MAX_PAIRS];
   logic [CNT_W-1:0] cnt_mem [MAX_PAIRS];
   logic            busy_mem [MAX_PAIRS];
   logic            strk_mem [DEPTH];

   state_type st_ff, st_in;
   logic [IW-1:0] sp_ff, sp_in, cur_ff, cur_in, j_ff, j_in, best_ff, best_in, prev_ff, prev_in;
   logic [RANK_W-1:0] best_r_ff, best_r_in, prev_r_ff, prev_r_in;
   logic          have_ff, have_in;
   logic [PW-1:0] tot_ff, tot_in;
   logic [GW-1:0] guard_ff, guard_in;
   logic [3:0]    qa_ff, qa_in;
   logic          qok_ff, qok_in;
   logic          rkind_ff, rkind_in, rpv_ff, rpv_in;
   logic [CNT_W-1:0] rprop_ff, rprop_in;
   logic [IW-1:0] rpart_ff, rpart_in;

   // Memory reads, registered.
   logic [IW-1:0] a_rd_idx, p_rd_idx;
   logic [AW-1:0] s_rd_addr;
   logic [IW-1:0] eng_q;
   logic          engv_q, busy_q, strk_q;
   logic [CNT_W-1:0] cnt_q;
   // Memory writes.
   logic          acc_we;
   logic [IW-1:0] acc_widx;
   logic [IW-1:0] acc_weng;
   logic          acc_wv;
   logic [CNT_W-1:0] acc_wcnt;
   logic          busy_we;
   logic [IW-1:0] busy_widx;
   logic          busy_wd;
   logic          busy2_we;
   logic [IW-1:0] busy2_widx;
   logic          strk_we, strk_wd;
   logic [AW-1:0] strk_waddr;

   always_ff @(posedge clock) begin
      eng_q  <= eng_mem[a_rd_idx];
      engv_q <= engv_mem[a_rd_idx];
      cnt_q  <= cnt_mem[a_rd_idx];
      busy_q <= busy_mem[p_rd_idx];
      strk_q <= strk_mem[s_rd_addr];
      if (acc_we) begin
         eng_mem[acc_widx]  <= acc_weng;
         engv_mem[acc_widx] <= acc_wv;
         cnt_mem[acc_widx]  <= acc_wcnt;
      end
      if (busy_we) busy_mem[busy_widx] <= busy_wd;
      if (busy2_we) busy_mem[busy2_widx] <= 1'b1;
      if (strk_we) strk_mem[strk_waddr] <= strk_wd;
   end
   // Set during the clearing pass after reset; that pass returns to idle
   // instead of starting a match.
   logic init_ff;

   // Rank memories.
   logic          pr_we, ar_we;
   logic [AW-1:0] pr_raddr, ar_raddr;
   logic [RANK_W-1:0] pr_q, ar_q;
   sme_rank_mem #(.DEPTH(DEPTH), .AW(AW)) u_prop_rank (
      .clock(clock), .wr_en(pr_we), .wr_addr({IW'(f_prop), IW'(f_acc)}),
      .wr_data(f_rank), .rd_addr(pr_raddr), .rd_data(pr_q));
   sme_rank_mem #(.DEPTH(DEPTH), .AW(AW)) u_acc_rank (
      .clock(clock), .wr_en(ar_we), .wr_addr({IW'(f_prop), IW'(f_acc)}),
      .wr_data(f_rank), .rd_addr(ar_raddr), .rd_data(ar_q));

   logic [PW-1:0] clr_ff, clr_in;
   logic [AW:0]   sclr_ff, sclr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         init_ff <= 1'b1;
         clr_ff <= '0;
         sclr_ff <= '0;
         tot_ff <= '0;
         sp_ff <= '0;
      end else begin
         st_ff <= st_in;
         init_ff <= (st_ff == ST_CLEAR && st_in != ST_CLEAR) ? 1'b0 : init_ff;
         clr_ff <= clr_in;
         sclr_ff <= sclr_in;
         tot_ff <= tot_in;
         sp_ff <= sp_in;
      end
      cur_ff <= cur_in; j_ff <= j_in; best_ff <= best_in; prev_ff <= prev_in;
      best_r_ff <= best_r_in; prev_r_ff <= prev_r_in; have_ff <= have_in;
      guard_ff <= guard_in; qa_ff <= qa_in; qok_ff <= qok_in;
      rkind_ff <= rkind_in; rpv_ff <= rpv_in; rprop_ff <= rprop_in; rpart_ff <= rpart_in;
   end

   logic [IW-1:0] n_last;
   assign n_last = IW'(n_act - PW'(1));

   always_comb begin
      st_in = st_ff; clr_in = clr_ff; sclr_in = sclr_ff; tot_in = tot_ff; sp_in = sp_ff;
      cur_in = cur_ff; j_in = j_ff; best_in = best_ff; prev_in = prev_ff;
      best_r_in = best_r_ff; prev_r_in = prev_r_ff; have_in = have_ff;
      guard_in = guard_ff; qa_in = qa_ff; qok_in = qok_ff;
      rkind_in = rkind_ff; rpv_in = rpv_ff; rprop_in = rprop_ff; rpart_in = rpart_ff;
      req_tready = 1'b0; pr_we = 1'b0; ar_we = 1'b0;
      a_rd_idx = '0; p_rd_idx = sp_ff; s_rd_addr = '0;
      pr_raddr = {cur_ff, j_ff}; ar_raddr = '0;
      acc_we = 1'b0; acc_widx = '0; acc_weng = '0; acc_wv = 1'b0;
      acc_wcnt = '0; busy_we = 1'b0; busy_widx = '0; busy_wd = 1'b0;
      busy2_we = 1'b0; busy2_widx = cur_ff;
      strk_we = 1'b0; strk_wd = 1'b0; strk_waddr = '0;
      unique case (st_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (f_cmd)
                  CMD_LOAD_PROP: pr_we = p_ok && a_ok;
                  CMD_LOAD_ACC:  ar_we = p_ok && a_ok;
                  CMD_RUN: begin
                     st_in = ST_CLEAR; clr_in = '0; sclr_in = '0;
                  end
                  CMD_QUERY: begin
                     qa_in = f_acc; qok_in = a_ok; st_in = ST_QUERY;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            // Clears one strike row entry per cycle, plus one acceptor and one proposer entry while any remain.
            acc_we = 32'(clr_ff) < MAX_PAIRS; acc_widx = IW'(clr_ff);
            busy_we = 32'(clr_ff) < MAX_PAIRS; busy_widx = IW'(clr_ff);
            strk_we = 1'b1; strk_waddr = AW'(sclr_ff);
            sclr_in = sclr_ff + 1'b1;
            if (32'(clr_ff) < MAX_PAIRS) clr_in = clr_ff + 1'b1;
            if (32'(sclr_ff) == DEPTH - 1) begin
               tot_in = '0; sp_in = '0; guard_in = GUARD_INIT;
               st_in = init_ff ? ST_IDLE : ST_FIND;
            end
         end
         ST_FIND: begin
            // The busy read of sp_ff issued here is seen as busy_q in ST_SCAN_ADDR.
            if (tot_ff == n_act || guard_ff == '0) begin
               rkind_in = 1'b0; rpv_in = 1'b0; rprop_in = '0; rpart_in = '0;
               st_in = ST_REPLY;
            end else begin
               st_in = ST_SCAN_ADDR;
               p_rd_idx = sp_ff;
            end
         end
         ST_SCAN_ADDR: begin
            if (busy_q) begin
               sp_in = (sp_ff == n_last) ? '0 : sp_ff + 1'b1;
               p_rd_idx = (sp_ff == n_last) ? '0 : sp_ff + 1'b1;
            end else begin
               cur_in = sp_ff; j_in = '0; have_in = 1'b0;
               guard_in = guard_ff - 1'b1;
               pr_raddr = {sp_ff, IW'(0)}; s_rd_addr = {sp_ff, IW'(0)};
               st_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // pr_q and strk_q hold entry j_ff of the current proposer's row.
            if (!strk_q && (!have_ff || pr_q < best_r_ff)) begin
               best_in = j_ff; best_r_in = pr_q; have_in = 1'b1;
            end
            pr_raddr = {cur_ff, j_ff + 1'b1}; s_rd_addr = {cur_ff, j_ff + 1'b1};
            j_in = j_ff + 1'b1;
            if (j_ff == n_last) begin
               if (!strk_q || have_ff) st_in = ST_ACC_ADDR;
               else begin
                  rkind_in = 1'b0; rpv_in = 1'b0; rprop_in = '0; rpart_in = '0;
                  st_in = ST_REPLY;
               end
            end
         end
         ST_ACC_ADDR: begin
            a_rd_idx = best_ff; st_in = ST_ACC_PREV;
         end
         ST_ACC_PREV: begin
            prev_in = eng_q;
            ar_raddr = {eng_q, best_ff};
            acc_we = 1'b1; acc_widx = best_ff; acc_weng = eng_q; acc_wv = engv_q;
            acc_wcnt = (cnt_q < CNT_SAT) ? cnt_q + 1'b1 : cnt_q;
            if (!engv_q) begin
               acc_weng = cur_ff; acc_wv = 1'b1;
               busy2_we = 1'b1; tot_in = tot_ff + 1'b1;
               p_rd_idx = sp_ff; st_in = ST_FIND;
            end else begin
               rprop_in = acc_wcnt; st_in = ST_ACC_NEW;
            end
         end
         ST_ACC_NEW: begin
            prev_r_in = ar_q; ar_raddr = {cur_ff, best_ff}; st_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            p_rd_idx = sp_ff;
            if (prev_r_ff > ar_q) begin
               acc_we = 1'b1; acc_widx = best_ff; acc_weng = cur_ff; acc_wv = 1'b1;
               acc_wcnt = rprop_ff;
               busy_we = 1'b1; busy_widx = prev_ff; busy_wd = 1'b0;
               busy2_we = 1'b1;
               strk_we = 1'b1; strk_wd = 1'b1; strk_waddr = {prev_ff, best_ff};
            end else begin
               strk_we = 1'b1; strk_wd = 1'b1; strk_waddr = {cur_ff, best_ff};
            end
            st_in = ST_FIND;
         end
         ST_QUERY: begin
            a_rd_idx = IW'(qa_ff); st_in = ST_REPLY;
            rkind_in = 1'b1;
         end
         ST_REPLY: ;
         default: st_in = ST_IDLE;
      endcase
      // Query data arrives in the cycle after the address.
      if (st_ff == ST_REPLY && rkind_ff && qok_ff) begin
         rprop_in = cnt_q; rpart_in = eng_q; rpv_in = engv_q; qok_in = 1'b0;
      end
      if (st_ff == ST_QUERY && !qok_ff) begin
         rprop_in = '0; rpart_in = '0; rpv_in = 1'b0;
      end
      if (st_ff == ST_REPLY && rsp_tready && !(rkind_ff && qok_ff)) st_in = ST_IDLE;
   end

   assign rsp_tvalid = (st_ff == ST_REPLY) && !(rkind_ff && qok_ff);
   assign rsp_tuser  = rkind_ff;
   assign rsp_tdata  = {6'd0, rpv_ff, 4'(rpart_ff), rprop_ff};
endmodule

@@ hdl/sme_rank_mem.sv @@
// Synchronous rank memory, one write port and one registered read port.
module sme_rank_mem #(
   parameter int DEPTH = 256,
   parameter int AW = 8
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [sme_pkg::RANK_W-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr,
   output logic [sme_pkg::RANK_W-1:0] rd_data
);
   import sme_pkg::*;
   logic [RANK_W-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ hdl/sme_checker.sv @@
// Port-level checker for the stable matching engine, bound to the top level.
module sme_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while reply pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("reply dropped while stalled");
   a_run_reply_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 16'd0) else $error("run reply not zero");
   a_load_no_reply: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[1] |=> !rsp_tvalid)
      else $error("load produced a reply");
endmodule

bind stable_matching_engine_core sme_checker u_sme_checker (.*);

@@ dv/tb_stable_matching_engine_core.sv @@
// Self-checking testbench for the stable matching engine core.
`timescale 1ns / 100ps

module tb_stable_matching_engine_core;
   import sme_pkg::*;

   localparam int NP          = DEFAULT_MAX_PAIRS;
   localparam int DRAIN_QUIET = 40;        // idle cycles before a register write or drain
   localparam int TAIL_CYCLES = 200;       // settle time after the last accepted request
   localparam int CYCLE_LIMIT = 3000000;   // generous bound on the whole run
   localparam logic REPLY_DONE  = 1'b0;
   localparam logic REPLY_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ITEM_REQ,
      ITEM_CFG,
      ITEM_DRAIN
   } item_kind_type;

   typedef struct {
      item_kind_type kind;
      cmd_type    cmd;
      logic [3:0] proposer;
      logic [3:0] acceptor;
      logic [4:0] rank_value;
      logic [4:0] cfg_value;
   } stim_type;

   typedef struct packed {
      logic       reply_kind;
      logic [4:0] proposals;
      logic [3:0] partner;
      logic       partner_valid;
   } reply_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // proposer[3:0], acceptor[7:4], rank_value[12:8]
   logic [1:0]  req_tuser;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // proposals[4:0], partner[8:5], partner_valid[9]
   logic        rsp_tuser;   // reply_kind
   logic        csr_wr_en;
   logic [4:0]  csr_wr_data;

   stim_type  pending_items[$];
   reply_type expected_replies[$];
   int     total_items;
   int     accepted_count;
   int     quiet_cycles;
   int     cycle_count;
   int     mismatch_count;
   int     fail_count;

   // Predictor copy of the engine state.
   logic [4:0] prop_rank [NP][NP];
   logic [4:0] acc_rank  [NP][NP];
   logic       struck    [NP][NP];
   logic [3:0] engaged_to [NP];
   logic       engaged_ok [NP];
   logic [4:0] offer_count [NP];
   logic       prop_busy  [NP];
   logic [4:0] pairs_cfg;

   // Stimulus-side bookkeeping of which rank entries hold data.
   bit gen_prop_written [NP][NP];
   bit gen_acc_written  [NP][NP];

   stable_matching_engine_core #(.MAX_PAIRS(NP)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Pairs actually taking part: zero acts as one, large values clamp.
   function automatic int effective_pairs(logic [4:0] value);
      if (value == 5'd0) return 1;
      if (value > NP) return NP;
      return int'(value);
   endfunction

   // Proposer-side Gale-Shapley over the predictor's rank tables.
   task automatic predict_matching();
      int n, guard, total, ptr, i, best, prev;
      n = effective_pairs(pairs_cfg);
      guard = NP * NP + NP;
      total = 0;
      ptr = 0;
      for (int a = 0; a < NP; a++) begin
         engaged_to[a] = '0;
         engaged_ok[a] = 1'b0;
         offer_count[a] = '0;
         prop_busy[a] = 1'b0;
         for (int b = 0; b < NP; b++) struck[a][b] = 1'b0;
      end
      while (total != n && guard != 0) begin
         guard--;
         while (prop_busy[ptr]) ptr = (ptr + 1) % n;
         i = ptr;
         best = n;
         for (int j = 0; j < n; j++) begin
            if (!struck[i][j] && (best == n || prop_rank[i][j] < prop_rank[i][best]))
               best = j;
         end
         // An exhausted proposer ends the run early.
         if (best >= n) break;
         if (offer_count[best] != CNT_SAT) offer_count[best]++;
         if (!engaged_ok[best]) begin
            engaged_ok[best] = 1'b1;
            engaged_to[best] = 4'(i);
            prop_busy[i] = 1'b1;
            total++;
         end else begin
            prev = engaged_to[best];
            if (acc_rank[prev][best] > acc_rank[i][best]) begin
               prop_busy[prev] = 1'b0;
               struck[prev][best] = 1'b1;
               engaged_to[best] = 4'(i);
               prop_busy[i] = 1'b1;
            end
         end
         if (!prop_busy[i]) struck[i][best] = 1'b1;
      end
   endtask

   // Applies one accepted transaction and queues any reply it causes.
   task automatic predict_transaction(stim_type it);
      reply_type r;
      r.reply_kind = REPLY_DONE;
      r.proposals = '0;
      r.partner = '0;
      r.partner_valid = 1'b0;
      case (it.cmd)
         CMD_LOAD_PROP: prop_rank[it.proposer][it.acceptor] = it.rank_value;
         CMD_LOAD_ACC:  acc_rank[it.proposer][it.acceptor] = it.rank_value;
         CMD_RUN: begin
            predict_matching();
            expected_replies.push_back(r);
         end
         default: begin
            r.reply_kind = REPLY_QUERY;
            r.proposals = offer_count[it.acceptor];
            if (engaged_ok[it.acceptor]) begin
               r.partner = engaged_to[it.acceptor];
               r.partner_valid = 1'b1;
            end
            expected_replies.push_back(r);
         end
      endcase
   endtask

   task automatic add_req(cmd_type c, int p, int a, int r);
      stim_type it;
      it.kind = ITEM_REQ;
      it.cmd = c;
      it.proposer = 4'(p);
      it.acceptor = 4'(a);
      it.rank_value = 5'(r);
      it.cfg_value = '0;
      if (c == CMD_LOAD_PROP) gen_prop_written[p][a] = 1'b1;
      if (c == CMD_LOAD_ACC) gen_acc_written[p][a] = 1'b1;
      pending_items.push_back(it);
   endtask

   task automatic add_marker(item_kind_type k, int value);
      stim_type it;
      it.kind = k;
      it.cmd = CMD_QUERY;
      it.proposer = '0;
      it.acceptor = '0;
      it.rank_value = '0;
      it.cfg_value = 5'(value);
      pending_items.push_back(it);
   endtask

   // Loads every still-empty entry of the n x n tables, then runs the match.
   task automatic add_complete_run(int n);
      for (int p = 0; p < n; p++) begin
         for (int a = 0; a < n; a++) begin
            if (!gen_prop_written[p][a]) add_req(CMD_LOAD_PROP, p, a, $urandom_range(31));
            if (!gen_acc_written[p][a]) add_req(CMD_LOAD_ACC, p, a, $urandom_range(31));
         end
      end
      add_req(CMD_RUN, $urandom_range(15), $urandom_range(15), $urandom_range(31));
   endtask

   // Stimulus generation: directed cases first, then randomized phases.
   initial begin
      int cfg, n, loads, cmd_sel;
      // Reset state of the first and last acceptor is visible before any run.
      add_req(CMD_QUERY, 0, 0, 0);
      add_req(CMD_QUERY, 15, 15, 31);
      // Two pairs with extreme ranks and a tie in the acceptor table.
      add_marker(ITEM_CFG, 2);
      add_req(CMD_LOAD_PROP, 0, 0, 0);
      add_req(CMD_LOAD_PROP, 0, 1, 31);
      add_req(CMD_LOAD_PROP, 1, 0, 1);
      add_req(CMD_LOAD_PROP, 1, 1, 16);
      add_req(CMD_LOAD_ACC, 0, 0, 16);
      add_req(CMD_LOAD_ACC, 0, 1, 1);
      add_req(CMD_LOAD_ACC, 1, 0, 16);
      add_req(CMD_LOAD_ACC, 1, 1, 31);
      add_req(CMD_RUN, 0, 0, 0);
      add_req(CMD_QUERY, 0, 0, 0);
      add_req(CMD_QUERY, 0, 1, 0);
      // An index beyond the pairs in use shows the cleared entry.
      add_req(CMD_QUERY, 0, 15, 0);
      // Equal proposer ranks: the lowest acceptor index wins the tie.
      add_req(CMD_LOAD_PROP, 1, 0, 31);
      add_req(CMD_LOAD_PROP, 1, 1, 31);
      add_req(CMD_RUN, 15, 15, 31);
      add_req(CMD_QUERY, 0, 0, 0);
      add_req(CMD_QUERY, 0, 1, 0);
      // A zero pair count behaves as a single pair.
      add_marker(ITEM_CFG, 0);
      add_req(CMD_RUN, 0, 0, 0);
      add_req(CMD_QUERY, 0, 0, 0);
      add_req(CMD_QUERY, 0, 1, 0);

      for (int phase = 0; phase < 32; phase++) begin
         if ($urandom_range(9) == 0) cfg = 0;
         else cfg = $urandom_range(1, 8);
         n = effective_pairs(5'(cfg));
         add_marker(ITEM_CFG, cfg);
         // Rewrites inside the active tables and, now and then, loads anywhere in the tables.
         loads = $urandom_range(2, 8);
         for (int k = 0; k < loads; k++) begin
            cmd_sel = $urandom_range(1);
            if ($urandom_range(3) == 0)
               add_req(cmd_type'(cmd_sel), $urandom_range(15), $urandom_range(15),
                       $urandom_range(31));
            else
               add_req(cmd_type'(cmd_sel), $urandom_range(n - 1), $urandom_range(n - 1),
                       $urandom_range(31));
         end
         if ($urandom_range(3) == 0) add_req(CMD_QUERY, 0, $urandom_range(15), 0);
         add_complete_run(n);
         for (int k = 0; k < $urandom_range(1, 4); k++)
            add_req(CMD_QUERY, $urandom_range(15), $urandom_range(15), $urandom_range(31));
         // Rerun on unchanged tables now and then.
         if ($urandom_range(4) == 0) begin
            add_req(CMD_RUN, 0, 0, 0);
            add_req(CMD_QUERY, 0, $urandom_range(n - 1), 0);
         end
         if ($urandom_range(5) == 0) add_marker(ITEM_DRAIN, 0);
      end
      total_items = pending_items.size();
   end

   // Reset is held at the start only.
   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Idle percentages per third of the run: sender then receiver.
   function automatic int sender_idle_pct();
      int third;
      third = (total_items == 0) ? 0 : accepted_count * 3 / total_items;
      if (third == 0) return 31;
      if (third == 1) return 78;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      int third;
      third = (total_items == 0) ? 0 : accepted_count * 3 / total_items;
      if (third == 0) return 78;
      if (third == 1) return 31;
      return 0;
   endfunction

   // Driver: presents one pending transaction at a time; register writes and
   // drain markers wait until the engine is idle and every reply is back.
   always @(posedge clock) begin
      stim_type head;
      logic  next_valid, next_wr, hold;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
         csr_wr_en <= 1'b0;
         csr_wr_data <= '0;
         pairs_cfg = 5'd16;
         quiet_cycles = 0;
         accepted_count = 0;
      end else begin
         hold = req_tvalid && !req_tready;
         quiet_cycles++;
         if (req_tvalid && req_tready) begin
            head = pending_items.pop_front();
            predict_transaction(head);
            accepted_count++;
            quiet_cycles = 0;
         end
         next_valid = hold;
         next_wr = 1'b0;
         if (!hold && pending_items.size() != 0) begin
            head = pending_items[0];
            if (head.kind != ITEM_REQ) begin
               if (expected_replies.size() == 0 && quiet_cycles >= DRAIN_QUIET) begin
                  void'(pending_items.pop_front());
                  quiet_cycles = 0;
                  if (head.kind == ITEM_CFG) begin
                     next_wr = 1'b1;
                     csr_wr_data <= head.cfg_value;
                     pairs_cfg = head.cfg_value;
                  end
               end
            end else if ($urandom_range(99) >= sender_idle_pct()) begin
               next_valid = 1'b1;
               req_tdata <= {3'b000, head.rank_value, head.acceptor, head.proposer};
               req_tuser <= head.cmd;
            end
         end
         req_tvalid <= next_valid;
         csr_wr_en <= next_wr;
      end
   end

   // Monitor: checks each reply transaction against the oldest expectation.
   always @(posedge clock) begin
      reply_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         mismatch_count = 0;
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.reply_kind = rsp_tuser;
            got.proposals = rsp_tdata[4:0];
            got.partner = rsp_tdata[8:5];
            got.partner_valid = rsp_tdata[9];
            if (expected_replies.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected reply kind=%0d proposals=%0d partner=%0d valid=%0d",
                           got.reply_kind, got.proposals, got.partner, got.partner_valid);
            end else begin
               want = expected_replies.pop_front();
               if (got != want) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("reply mismatch: expected kind=%0d proposals=%0d partner=%0d valid=%0d",
                              want.reply_kind, want.proposals, want.partner,
                              want.partner_valid);
                     $display("                actual kind=%0d proposals=%0d partner=%0d valid=%0d",
                              got.reply_kind, got.proposals, got.partner, got.partner_valid);
                  end
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // End of test: all stimulus taken, all replies back, then a quiet tail.
   always @(posedge clock) begin
      if (reset) begin
         cycle_count = 0;
      end else begin
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end else if (total_items != 0 && pending_items.size() == 0 && !req_tvalid &&
                      expected_replies.size() == 0 && quiet_cycles >= TAIL_CYCLES) begin
            if (fail_count == 0) begin
               $display("PASS");
            end else begin
               $display("FAIL");
            end
            $finish;
         end
      end
   end

endmodule
